>>> design/mfhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfhp_pkg
// Beat types, address mode codes and header size constants for the
// 802.15.4 MAC frame header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

  // byte counter and header length widths
  localparam int unsigned PosW  = 7;
  localparam int unsigned HlenW = 5;

  // header sizes in bytes
  localparam logic [HlenW-1:0] HdrBaseBytes = HlenW'(3);   // fcf + sequence number
  localparam logic [HlenW-1:0] ShortNoPan   = HlenW'(2);
  localparam logic [HlenW-1:0] ShortWithPan = HlenW'(4);
  localparam logic [HlenW-1:0] LongNoPan    = HlenW'(8);
  localparam logic [HlenW-1:0] LongWithPan  = HlenW'(8 + 2);
  localparam logic [HlenW-1:0] FcsBytes     = HlenW'(2);
  localparam logic [7:0]       ByteMask     = 8'hff;

  // address modes from the frame control field
  typedef enum logic [1:0] {
    AddrNone  = 2'd0,
    AddrRsvd  = 2'd1,
    AddrShort = 2'd2,
    AddrLong  = 2'd3
  } addr_mode_e;

  // input beat: one frame byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // output beat: one parsed header per frame
  typedef struct packed {
    logic [15:0]      frame_control;
    logic [2:0]       frame_type;
    logic [7:0]       sequence_number;
    logic [15:0]      dest_pan;
    logic [15:0]      dest_short_addr;
    logic [15:0]      source_pan;
    logic [15:0]      source_short_addr;
    logic [HlenW-1:0] header_length;
    logic [PosW-1:0]  payload_length;
    logic [PosW-1:0]  frame_length;
    logic             short_frame;
  } out_beat_t;

  // destination address field size
  function automatic logic [HlenW-1:0] dst_bytes(input addr_mode_e mode);
    logic [HlenW-1:0] n;
    case (mode)
      AddrShort: n = ShortWithPan;
      AddrLong:  n = LongWithPan;
      default:   n = '0;
    endcase
    return n;
  endfunction

  // source address field size, pan id dropped when intra-pan
  function automatic logic [HlenW-1:0] src_bytes(input addr_mode_e mode, input logic intra);
    logic [HlenW-1:0] n;
    case (mode)
      AddrShort: n = intra ? ShortNoPan : ShortWithPan;
      AddrLong:  n = intra ? LongNoPan : LongWithPan;
      default:   n = '0;
    endcase
    return n;
  endfunction

endpackage : mfhp_pkg
`default_nettype wire

>>> design/mac_frame_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mac_frame_header_parser_unit
// Parses the MAC header of a received 802.15.4 frame, one byte per beat.
//
// Input channel (in_valid_i / in_stall_o / in_beat_i) carries frame bytes from
// the frame control field through the FCS, last_byte set on the final byte.
// Output channel (out_valid_o / out_stall_i / out_beat_o) carries one beat per
// frame with the decoded header fields and the header, payload and frame
// lengths. Short addresses and PAN ids are captured, long ones skipped, and
// absent fields read zero.
// Each byte is absorbed in the cycle it is accepted; the result beat appears
// in the output register in the cycle after the last byte is accepted. One
// byte is taken every cycle unless a held result beat stalls the input, back
// to back across frames, set by the single byte capture stage feeding the
// output register. A pending result beat held by out_stall_i stalls the
// input; the payload in the output register holds while stalled.
// Reset clears the byte counter, captured fields and the output valid.
// Bytes past MAX_FRAME_BYTES are dropped and the frame length saturates.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_unit
  import mfhp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     fcf_q, fcf_d;
  logic [7:0]      seq_q, seq_d;
  logic [15:0]     dpan_q, dpan_d;
  logic [15:0]     daddr_q, daddr_d;
  logic [15:0]     span_q, span_d;
  logic [15:0]     saddr_q, saddr_d;

  logic            out_valid_q;
  out_beat_t       out_q, out_d;
  logic            in_acc;

  // modes during capture, from the complete fcf
  addr_mode_e      cap_dm, cap_sm;
  logic            cap_ip;
  logic [PosW-1:0] src_off, rel;

  // modes at the final byte, from the updated fcf
  addr_mode_e      fin_dm, fin_sm;
  logic            fin_ip;
  logic [HlenW-1:0] hlen;
  logic [PosW-1:0]  need;
  logic             shortf;
  logic [7:0]       b;

  // handshake
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign b           = in_beat_i.data_byte & ByteMask;

  // byte capture
  always_comb begin
    cap_dm  = addr_mode_e'(fcf_q[11:10]);
    cap_sm  = addr_mode_e'(fcf_q[15:14]);
    cap_ip  = fcf_q[6];
    src_off = PosW'(HdrBaseBytes + dst_bytes(cap_dm));
    rel     = pos_q - src_off;

    pos_d   = pos_q;
    fcf_d   = fcf_q;
    seq_d   = seq_q;
    dpan_d  = dpan_q;
    daddr_d = daddr_q;
    span_d  = span_q;
    saddr_d = saddr_q;

    if (pos_q < MaxPos) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == PosW'(0)) begin
        fcf_d = {8'h00, b};
      end else if (pos_q == PosW'(1)) begin
        fcf_d[15:8] = b;
      end else if (pos_q == PosW'(2)) begin
        seq_d = b;
      end else begin
        // destination pan and short address
        if (cap_dm == AddrShort) begin
          if (pos_q == PosW'(3)) dpan_d[7:0]   = b;
          if (pos_q == PosW'(4)) dpan_d[15:8]  = b;
          if (pos_q == PosW'(5)) daddr_d[7:0]  = b;
          if (pos_q == PosW'(6)) daddr_d[15:8] = b;
        end
        // source pan and short address, pan omitted when intra-pan
        if (cap_sm == AddrShort && pos_q >= src_off) begin
          if (!cap_ip) begin
            if (rel == PosW'(0)) span_d[7:0]   = b;
            if (rel == PosW'(1)) span_d[15:8]  = b;
            if (rel == PosW'(2)) saddr_d[7:0]  = b;
            if (rel == PosW'(3)) saddr_d[15:8] = b;
          end else begin
            if (rel == PosW'(0)) saddr_d[7:0]  = b;
            if (rel == PosW'(1)) saddr_d[15:8] = b;
          end
        end
      end
    end
  end

  // result for the final byte
  always_comb begin
    fin_dm = addr_mode_e'(fcf_d[11:10]);
    fin_sm = addr_mode_e'(fcf_d[15:14]);
    fin_ip = fcf_d[6];
    hlen   = HdrBaseBytes + dst_bytes(fin_dm) + src_bytes(fin_sm, fin_ip);
    need   = PosW'(hlen) + PosW'(FcsBytes);
    shortf = pos_d < need;

    out_d.frame_control     = fcf_d;
    out_d.frame_type        = fcf_d[2:0];
    out_d.sequence_number   = seq_d;
    out_d.dest_pan          = (fin_dm == AddrShort) ? dpan_d : 16'h0000;
    out_d.dest_short_addr   = (fin_dm == AddrShort) ? daddr_d : 16'h0000;
    if (fin_sm == AddrShort) begin
      out_d.source_pan = fin_ip ? out_d.dest_pan : span_d;
    end else begin
      out_d.source_pan = 16'h0000;
    end
    out_d.source_short_addr = (fin_sm == AddrShort) ? saddr_d : 16'h0000;
    out_d.header_length     = hlen;
    out_d.payload_length    = shortf ? '0 : pos_d - need;
    out_d.frame_length      = pos_d;
    out_d.short_frame       = shortf;
  end

  // frame state, cleared after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fcf_q   <= '0;
      seq_q   <= '0;
      dpan_q  <= '0;
      daddr_q <= '0;
      span_q  <= '0;
      saddr_q <= '0;
    end else if (in_acc) begin
      if (in_beat_i.last_byte) begin
        pos_q   <= '0;
        fcf_q   <= '0;
        seq_q   <= '0;
        dpan_q  <= '0;
        daddr_q <= '0;
        span_q  <= '0;
        saddr_q <= '0;
      end else begin
        pos_q   <= pos_d;
        fcf_q   <= fcf_d;
        seq_q   <= seq_d;
        dpan_q  <= dpan_d;
        daddr_q <= daddr_d;
        span_q  <= span_d;
        saddr_q <= saddr_d;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && in_beat_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc && in_beat_i.last_byte) begin
      out_q <= out_d;
    end
  end

endmodule : mac_frame_header_parser_unit
`default_nettype wire

>>> tb/tb_mac_frame_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mac_frame_header_parser_unit
// Feeds 802.15.4 MAC frames into the header parser one byte per beat and
// checks every parsed header beat against a behavioral parser kept in the
// testbench. Directed frames cover the address mode combinations, truncated
// headers and the frame length limit; random frames follow, with bursty input
// and a receiver that stalls in its own pattern.
// ----------------------------------------------------------------------------
module tb_mac_frame_header_parser_unit;
  import mfhp_pkg::*;

  localparam int unsigned MaxFrameBytes = 127;
  localparam int unsigned RandomBytes   = 600;
  localparam int unsigned FcsLen        = 2;
  localparam int unsigned DrainCycles   = 8;

  typedef enum logic [1:0] {
    StallNever,
    StallSome,
    StallMost
  } stall_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // parsed headers still to come out of the block
  out_beat_t expected_headers[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned burst_left     = 0;

  // behavioral parser state, cleared after every final byte
  int unsigned byte_count  = 0;
  logic [15:0] fcf_seen    = '0;
  logic [7:0]  seq_seen    = '0;
  logic [15:0] dpan_seen   = '0;
  logic [15:0] daddr_seen  = '0;
  logic [15:0] span_seen   = '0;
  logic [15:0] saddr_seen  = '0;

  mac_frame_header_parser_unit #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always #10 clk_i = ~clk_i;

  // bytes taken by an address field, pan id included when with_pan is set
  function automatic int unsigned addr_field_len(input addr_mode_e mode, input logic with_pan);
    case (mode)
      AddrShort: return with_pan ? 4 : 2;
      AddrLong:  return with_pan ? 10 : 8;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned header_len(input logic [15:0] fcf);
    return 3 + addr_field_len(addr_mode_e'(fcf[11:10]), 1'b1)
             + addr_field_len(addr_mode_e'(fcf[15:14]), !fcf[6]);
  endfunction

  // absorb one accepted byte; queue a parsed header on the final byte
  function automatic void absorb_frame_byte(input in_beat_t beat);
    addr_mode_e  dm;
    addr_mode_e  sm;
    logic        ip;
    int unsigned off;
    int unsigned rel;
    int unsigned need;
    out_beat_t   hdr;
    dm = addr_mode_e'(fcf_seen[11:10]);
    sm = addr_mode_e'(fcf_seen[15:14]);
    ip = fcf_seen[6];
    if (byte_count < MaxFrameBytes) begin
      case (byte_count)
        0: fcf_seen = {8'h00, beat.data_byte};
        1: fcf_seen[15:8] = beat.data_byte;
        2: seq_seen = beat.data_byte;
        default: begin
          if (dm == AddrShort) begin
            if (byte_count < 5) dpan_seen[8*(byte_count-3) +: 8] = beat.data_byte;
            else if (byte_count < 7) daddr_seen[8*(byte_count-5) +: 8] = beat.data_byte;
          end
          off = 3 + addr_field_len(dm, 1'b1);
          if (sm == AddrShort && byte_count >= off) begin
            rel = byte_count - off;
            if (!ip) begin
              if (rel < 2) span_seen[8*rel +: 8] = beat.data_byte;
              else if (rel < 4) saddr_seen[8*(rel-2) +: 8] = beat.data_byte;
            end else if (rel < 2) begin
              saddr_seen[8*rel +: 8] = beat.data_byte;
            end
          end
        end
      endcase
      byte_count++;
    end
    if (!beat.last_byte) return;

    dm   = addr_mode_e'(fcf_seen[11:10]);
    sm   = addr_mode_e'(fcf_seen[15:14]);
    ip   = fcf_seen[6];
    need = header_len(fcf_seen) + FcsLen;
    hdr.frame_control     = fcf_seen;
    hdr.frame_type        = fcf_seen[2:0];
    hdr.sequence_number   = seq_seen;
    hdr.dest_pan          = (dm == AddrShort) ? dpan_seen : '0;
    hdr.dest_short_addr   = (dm == AddrShort) ? daddr_seen : '0;
    hdr.source_pan        = (sm != AddrShort) ? '0 : (ip ? hdr.dest_pan : span_seen);
    hdr.source_short_addr = (sm == AddrShort) ? saddr_seen : '0;
    hdr.header_length     = HlenW'(header_len(fcf_seen));
    hdr.short_frame       = (byte_count < need);
    hdr.payload_length    = hdr.short_frame ? '0 : PosW'(byte_count - need);
    hdr.frame_length      = PosW'(byte_count);
    expected_headers.push_back(hdr);

    byte_count = 0;
    fcf_seen   = '0;
    seq_seen   = '0;
    dpan_seen  = '0;
    daddr_seen = '0;
    span_seen  = '0;
    saddr_seen = '0;
  endfunction

  // send one byte, opening a new burst after a random gap when the old one ends
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: data, last_byte: last};
    do @(posedge clk_i); while (in_stall);
    absorb_frame_byte('{data_byte: data, last_byte: last});
    bytes_sent++;
  endtask

  // a frame of len bytes: frame control first, everything after it random
  task automatic send_frame(input logic [15:0] fcf, input int unsigned len);
    logic [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0:       data = fcf[7:0];
        1:       data = fcf[15:8];
        default: data = 8'($urandom);
      endcase
      send_byte(data, i == len - 1);
    end
  endtask

  function automatic logic [15:0] make_fcf(input addr_mode_e dm, input addr_mode_e sm,
                                           input logic ip);
    logic [15:0] fcf;
    fcf = 16'($urandom);
    fcf[11:10] = dm;
    fcf[15:14] = sm;
    fcf[6]     = ip;
    return fcf;
  endfunction

  // hold the input until every queued header has come out
  task automatic wait_for_headers();
    @(negedge clk_i);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_headers.size() != 0) @(posedge clk_i);
  endtask

  // well-formed frames over the address mode combinations and field extremes
  task automatic test_header_forms();
    logic [15:0] fcf;
    send_frame(16'h0000, 5);
    fcf = 16'hffff;
    send_frame(fcf, header_len(fcf) + FcsLen + 1);
    fcf = make_fcf(AddrShort, AddrShort, 1'b0);
    send_frame(fcf, header_len(fcf) + FcsLen + 3);
    fcf = make_fcf(AddrShort, AddrShort, 1'b1);
    send_frame(fcf, header_len(fcf) + FcsLen);
    // intra-pan with a long destination leaves no pan id to copy
    fcf = make_fcf(AddrLong, AddrShort, 1'b1);
    send_frame(fcf, header_len(fcf) + FcsLen + 2);
    fcf = make_fcf(AddrRsvd, AddrRsvd, 1'b0);
    send_frame(fcf, header_len(fcf) + FcsLen + 1);
    fcf = make_fcf(AddrShort, AddrLong, 1'b0);
    send_frame(fcf, header_len(fcf) + FcsLen);
    fcf = make_fcf(AddrNone, AddrShort, 1'b0);
    send_frame(fcf, header_len(fcf) + FcsLen + 1);
  endtask

  // frames that end inside the frame control, the header or the fcs
  task automatic test_truncated_frames();
    logic [15:0] fcf;
    send_frame(16'hffff, 1);
    send_frame(make_fcf(AddrShort, AddrShort, 1'b0), 2);
    send_frame(make_fcf(AddrShort, AddrShort, 1'b0), 3);
    send_frame(make_fcf(AddrShort, AddrShort, 1'b0), 6);
    fcf = make_fcf(AddrShort, AddrShort, 1'b1);
    send_frame(fcf, header_len(fcf) + FcsLen - 1);
  endtask

  // frames at and past the maximum length, then a normal one after
  task automatic test_length_limit();
    logic [15:0] fcf;
    fcf = make_fcf(AddrShort, AddrShort, 1'b0);
    send_frame(fcf, MaxFrameBytes);
    send_frame(make_fcf(AddrShort, AddrLong, 1'b1), MaxFrameBytes + 4);
    send_frame(fcf, header_len(fcf) + FcsLen);
  endtask

  // random frames, mostly well formed, some cut short or overlong
  task automatic test_random_traffic();
    logic [15:0] fcf;
    int unsigned hl;
    int unsigned len;
    int unsigned kind;
    int unsigned start;
    bit          drained;
    start   = bytes_sent;
    drained = 1'b0;
    while (bytes_sent - start < RandomBytes) begin
      fcf  = make_fcf(addr_mode_e'($urandom_range(0, 3)), addr_mode_e'($urandom_range(0, 3)),
                      1'($urandom));
      hl   = header_len(fcf);
      kind = $urandom_range(0, 49);
      if (kind < 36) begin
        len = hl + FcsLen + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 125 - hl)
                                                           : $urandom_range(0, 12));
      end else if (kind < 42) begin
        len = $urandom_range(1, hl + FcsLen - 1);
      end else if (kind < 49) begin
        len = $urandom_range(1, 40);
      end else begin
        len = $urandom_range(MaxFrameBytes - 7, MaxFrameBytes + 7);
      end
      send_frame(fcf, len);
      if (!drained && bytes_sent - start >= RandomBytes / 2) begin
        wait_for_headers();
        drained = 1'b1;
      end
    end
  endtask

  // receiver stall pattern: stretches of no, some or heavy backpressure
  stall_mode_e stall_mode = StallNever;
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      StallNever: out_stall <= 1'b0;
      StallSome:  out_stall <= ($urandom_range(0, 2) == 0);
      default:    out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // check each header beat against the oldest queued header
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_headers.size() == 0) begin
        $display("%0t: header beat expected none actual %0h", $time, out_beat);
        mismatch_count++;
      end else begin
        want = expected_headers.pop_front();
        compare_field("frame_control", want.frame_control, out_beat.frame_control);
        compare_field("frame_type", want.frame_type, out_beat.frame_type);
        compare_field("sequence_number", want.sequence_number, out_beat.sequence_number);
        compare_field("dest_pan", want.dest_pan, out_beat.dest_pan);
        compare_field("dest_short_addr", want.dest_short_addr, out_beat.dest_short_addr);
        compare_field("source_pan", want.source_pan, out_beat.source_pan);
        compare_field("source_short_addr", want.source_short_addr,
                      out_beat.source_short_addr);
        compare_field("header_length", want.header_length, out_beat.header_length);
        compare_field("payload_length", want.payload_length, out_beat.payload_length);
        compare_field("frame_length", want.frame_length, out_beat.frame_length);
        compare_field("short_frame", want.short_frame, out_beat.short_frame);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_header_forms();
    test_truncated_frames();
    test_length_limit();
    test_random_traffic();

    wait_for_headers();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_headers.size() != 0) begin
      $display("%0t: %0d header beats expected actual none", $time,
               expected_headers.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run time limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
